// ===== rtl/lbrm_pkg.sv =====
// ============================================================================
// lbrm_pkg
// Shared types and codes for the block residency manager.
// ============================================================================
package lbrm_pkg;

   localparam int unsigned CmdW   = 2;
   localparam int unsigned IdW    = 32;
   localparam int unsigned FrameW = 32;
   localparam int unsigned KindW  = 3;
   localparam int unsigned BlockW = 24;
   localparam int unsigned SlotW  = 6;
   localparam int unsigned StampW = 32;

   localparam int unsigned CsrIdxW  = 2;
   localparam int unsigned CsrDataW = 25;
   localparam int unsigned SiuW     = 7;
   localparam int unsigned TotalW   = 25;
   localparam int unsigned BudgetW  = 11;

   localparam logic [CmdW-1:0] CmdFrame   = 2'd0;
   localparam logic [CmdW-1:0] CmdTouch   = 2'd1;
   localparam logic [CmdW-1:0] CmdRequest = 2'd2;

   localparam logic [KindW-1:0] KindHit    = 3'd0;
   localparam logic [KindW-1:0] KindMiss   = 3'd1;
   localparam logic [KindW-1:0] KindEvict  = 3'd2;
   localparam logic [KindW-1:0] KindLoad   = 3'd3;
   localparam logic [KindW-1:0] KindRange  = 3'd4;
   localparam logic [KindW-1:0] KindBudget = 3'd5;
   localparam logic [KindW-1:0] KindFrame  = 3'd6;

   localparam logic [CsrIdxW-1:0] CsrSlotsInUse  = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrTotalBlocks = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrUploadBudget = 2'd2;

   localparam logic [SiuW-1:0]    SiuReset    = 7'd64;
   localparam logic [TotalW-1:0]  TotalReset  = 25'h100_0000;
   localparam logic [BudgetW-1:0] BudgetReset = 11'd64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic hit;
      logic free;
   } scan_flags_type;

endpackage

// ===== rtl/lbrm_dir.sv =====
// ============================================================================
// lbrm_dir
// Slot directory storage: valid flags plus block and stamp memories.
// ============================================================================
module lbrm_dir #(
   parameter int unsigned SLOTS = 64,
   parameter int unsigned IDX_W = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [IDX_W-1:0]                 rd_addr,
   input  logic                             wr_en,
   input  logic [IDX_W-1:0]                 wr_addr,
   input  logic [lbrm_pkg::BlockW-1:0]      wr_block,
   input  logic [lbrm_pkg::StampW-1:0]      wr_stamp,
   output logic                             rd_strobe,
   output logic [IDX_W-1:0]                 rd_idx,
   output logic                             rd_slot_valid,
   output logic [lbrm_pkg::BlockW-1:0]      rd_block,
   output logic [lbrm_pkg::StampW-1:0]      rd_stamp
);

   logic [lbrm_pkg::BlockW-1:0] block_mem [SLOTS];
   logic [lbrm_pkg::StampW-1:0] stamp_mem [SLOTS];
   logic [SLOTS-1:0]            valid_ff;

   logic                        rd_strobe_ff;
   logic [IDX_W-1:0]            rd_idx_ff;
   logic                        rd_valid_ff;
   logic [lbrm_pkg::BlockW-1:0] rd_block_ff;
   logic [lbrm_pkg::StampW-1:0] rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         block_mem[wr_addr] <= wr_block;
         stamp_mem[wr_addr] <= wr_stamp;
      end
      if (rd_en) begin
         rd_block_ff <= block_mem[rd_addr];
         rd_stamp_ff <= stamp_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rd_strobe_ff <= 1'b0;
      end else begin
         rd_strobe_ff <= rd_en;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_idx_ff   <= rd_addr;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_strobe     = rd_strobe_ff;
   assign rd_idx        = rd_idx_ff;
   assign rd_slot_valid = rd_valid_ff;
   assign rd_block      = rd_block_ff;
   assign rd_stamp      = rd_stamp_ff;

endmodule

// ===== rtl/lbrm_scan.sv =====
// ============================================================================
// lbrm_scan
// Shared compare unit that takes one slot per cycle while in_strobe is high
// and tracks a hit, the first free slot and the oldest stamp.
// ============================================================================
module lbrm_scan #(
   parameter int unsigned IDX_W = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           init,
   input  logic [lbrm_pkg::IdW-1:0]       key,
   input  logic                           in_strobe,
   input  logic [IDX_W-1:0]               in_idx,
   input  logic                           in_valid,
   input  logic [lbrm_pkg::BlockW-1:0]    in_block,
   input  logic [lbrm_pkg::StampW-1:0]    in_stamp,
   output lbrm_pkg::scan_flags_type       flags,
   output logic [IDX_W-1:0]               hit_idx,
   output logic [IDX_W-1:0]               free_idx,
   output logic [IDX_W-1:0]               old_idx,
   output logic [lbrm_pkg::BlockW-1:0]    old_block
);

   localparam int unsigned PadW = lbrm_pkg::IdW - lbrm_pkg::BlockW;

   lbrm_pkg::scan_flags_type    flags_ff;
   logic                        old_have_ff;
   logic [IDX_W-1:0]            hit_idx_ff;
   logic [IDX_W-1:0]            free_idx_ff;
   logic [IDX_W-1:0]            old_idx_ff;
   logic [lbrm_pkg::BlockW-1:0] old_block_ff;
   logic [lbrm_pkg::StampW-1:0] old_stamp_ff;

   logic match;
   logic older;

   assign match = in_valid && ({{PadW{1'b0}}, in_block} == key);
   assign older = !old_have_ff || (in_stamp < old_stamp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff    <= '0;
         old_have_ff <= 1'b0;
      end else if (init) begin
         flags_ff    <= '0;
         old_have_ff <= 1'b0;
      end else if (in_strobe) begin
         if (match && !flags_ff.hit) begin
            flags_ff.hit <= 1'b1;
         end
         if (!in_valid && !flags_ff.free) begin
            flags_ff.free <= 1'b1;
         end
         if (in_valid && older) begin
            old_have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!init && in_strobe) begin
         if (match && !flags_ff.hit) begin
            hit_idx_ff <= in_idx;
         end
         if (!in_valid && !flags_ff.free) begin
            free_idx_ff <= in_idx;
         end
         if (in_valid && older) begin
            old_idx_ff   <= in_idx;
            old_block_ff <= in_block;
            old_stamp_ff <= in_stamp;
         end
      end
   end

   assign flags     = flags_ff;
   assign hit_idx   = hit_idx_ff;
   assign free_idx  = free_idx_ff;
   assign old_idx   = old_idx_ff;
   assign old_block = old_block_ff;

endmodule

// ===== rtl/lru_block_residency_manager.sv =====
// ============================================================================
// lru_block_residency_manager
// LRU residency directory: tracks which blocks sit in which slots, serves
// touch and load requests and reports evictions under a per-frame budget.
// ============================================================================
// Touch and admitted requests walk the active slots one per cycle through a
// single compare unit, then a drain and a decide state (plus a load state
// on eviction). Frame start and rejected requests answer from idle; unused
// commands are ignored. Results appear in the cycle after their decision.
// Reset clears all valid flags, the frame and the upload count at once.
module lru_block_residency_manager #(
   parameter int unsigned SLOTS       = 64,
   parameter int unsigned MAX_UPLOADS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lbrm_pkg::CmdW-1:0]           req_cmd,
   input  logic [lbrm_pkg::IdW-1:0]            req_block_id,
   input  logic [lbrm_pkg::FrameW-1:0]         req_frame,
   output logic                                rsp_valid,
   output logic [lbrm_pkg::KindW-1:0]          rsp_kind,
   output logic [lbrm_pkg::BlockW-1:0]         rsp_block_out,
   output logic [lbrm_pkg::SlotW-1:0]          rsp_slot,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic [lbrm_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [lbrm_pkg::CsrDataW-1:0]       csr_wr_data
);

   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam int unsigned CW    = (IDX_W + 1 > lbrm_pkg::SiuW) ? IDX_W + 1 : lbrm_pkg::SiuW;
   localparam int unsigned UW    = $clog2(MAX_UPLOADS + 1);
   localparam int unsigned BCW   = (UW > lbrm_pkg::BudgetW) ? UW : lbrm_pkg::BudgetW;
   localparam int unsigned PadW  = lbrm_pkg::IdW - lbrm_pkg::TotalW;
   localparam logic [CW-1:0]    SlotsCw   = CW'(SLOTS);
   localparam logic [IDX_W-1:0] LastSlot  = IDX_W'(SLOTS - 1);
   localparam logic [BCW-1:0]   MaxUpBcw  = BCW'(MAX_UPLOADS);
   localparam logic [UW-1:0]    MaxUpUw   = UW'(MAX_UPLOADS);

   lbrm_pkg::state_type state_ff, state_in;

   logic [lbrm_pkg::SiuW-1:0]    slots_in_use_ff;
   logic [lbrm_pkg::TotalW-1:0]  total_blocks_ff;
   logic [lbrm_pkg::BudgetW-1:0] upload_budget_ff;

   logic [lbrm_pkg::FrameW-1:0]  frame_ff, frame_in;
   logic [UW-1:0]                uploads_ff, uploads_in;
   logic [IDX_W-1:0]             cnt_ff, cnt_in;
   logic                         is_req_ff, is_req_in;
   logic [lbrm_pkg::IdW-1:0]     key_ff, key_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lbrm_pkg::KindW-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [lbrm_pkg::BlockW-1:0]  rsp_block_ff, rsp_block_in;
   logic [lbrm_pkg::SlotW-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         rd_en;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic                         rd_strobe;
   logic [IDX_W-1:0]             rd_idx;
   logic                         rd_slot_valid;
   logic [lbrm_pkg::BlockW-1:0]  rd_block;
   logic [lbrm_pkg::StampW-1:0]  rd_stamp;

   logic                         scan_init;
   lbrm_pkg::scan_flags_type     flags;
   logic [IDX_W-1:0]             hit_idx;
   logic [IDX_W-1:0]             free_idx;
   logic [IDX_W-1:0]             old_idx;
   logic [lbrm_pkg::BlockW-1:0]  old_block;
   logic [IDX_W-1:0]             victim;

   logic [CW-1:0]                siu_ext;
   logic [IDX_W-1:0]             last_idx;
   logic                         in_range;
   logic                         spent;

   lbrm_dir #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_dir (
      .clock         (clock),
      .reset         (reset),
      .rd_en         (rd_en),
      .rd_addr       (cnt_ff),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_block      (key_ff[lbrm_pkg::BlockW-1:0]),
      .wr_stamp      (frame_ff),
      .rd_strobe     (rd_strobe),
      .rd_idx        (rd_idx),
      .rd_slot_valid (rd_slot_valid),
      .rd_block      (rd_block),
      .rd_stamp      (rd_stamp)
   );

   lbrm_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .init      (scan_init),
      .key       (key_ff),
      .in_strobe (rd_strobe),
      .in_idx    (rd_idx),
      .in_valid  (rd_slot_valid),
      .in_block  (rd_block),
      .in_stamp  (rd_stamp),
      .flags     (flags),
      .hit_idx   (hit_idx),
      .free_idx  (free_idx),
      .old_idx   (old_idx),
      .old_block (old_block)
   );

   // The active slot count is clamped to at least one and at most SLOTS.
   assign siu_ext = CW'(slots_in_use_ff);
   always_comb begin
      if (siu_ext == '0) begin
         last_idx = '0;
      end else if (siu_ext > SlotsCw) begin
         last_idx = LastSlot;
      end else begin
         last_idx = IDX_W'(siu_ext - CW'(1));
      end
   end

   assign in_range = (req_block_id[lbrm_pkg::IdW-1:lbrm_pkg::BlockW] == '0) &&
                     (req_block_id < {{PadW{1'b0}}, total_blocks_ff});
   assign spent    = (BCW'(uploads_ff) >= BCW'(upload_budget_ff)) ||
                     (BCW'(uploads_ff) >= MaxUpBcw);
   assign victim   = flags.free ? free_idx : old_idx;
   assign busy     = (state_ff != lbrm_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff  <= lbrm_pkg::SiuReset;
         total_blocks_ff  <= lbrm_pkg::TotalReset;
         upload_budget_ff <= lbrm_pkg::BudgetReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lbrm_pkg::CsrSlotsInUse: begin
               slots_in_use_ff <= csr_wr_data[lbrm_pkg::SiuW-1:0];
            end
            lbrm_pkg::CsrTotalBlocks: begin
               total_blocks_ff <= csr_wr_data[lbrm_pkg::TotalW-1:0];
            end
            lbrm_pkg::CsrUploadBudget: begin
               upload_budget_ff <= csr_wr_data[lbrm_pkg::BudgetW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbrm_pkg::ST_IDLE;
         frame_ff     <= '0;
         uploads_ff   <= '0;
         cnt_ff       <= '0;
         is_req_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         uploads_ff   <= uploads_in;
         cnt_ff       <= cnt_in;
         is_req_ff    <= is_req_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_block_ff <= rsp_block_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      frame_in     = frame_ff;
      uploads_in   = uploads_ff;
      cnt_in       = cnt_ff;
      is_req_in    = is_req_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_block_in = rsp_block_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = victim;
      scan_init    = 1'b0;

      unique case (state_ff)
         lbrm_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_cmd)
                  lbrm_pkg::CmdFrame: begin
                     frame_in     = req_frame;
                     uploads_in   = '0;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = lbrm_pkg::KindFrame;
                     rsp_block_in = '0;
                     rsp_slot_in  = '0;
                     rsp_last_in  = 1'b1;
                  end
                  lbrm_pkg::CmdTouch: begin
                     key_in    = req_block_id;
                     is_req_in = 1'b0;
                     cnt_in    = '0;
                     scan_init = 1'b1;
                     state_in  = lbrm_pkg::ST_SCAN;
                  end
                  lbrm_pkg::CmdRequest: begin
                     if (!in_range || spent) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = in_range ? lbrm_pkg::KindBudget
                                                : lbrm_pkg::KindRange;
                        rsp_block_in = req_block_id[lbrm_pkg::BlockW-1:0];
                        rsp_slot_in  = '0;
                        rsp_last_in  = 1'b1;
                     end else begin
                        key_in    = req_block_id;
                        is_req_in = 1'b1;
                        cnt_in    = '0;
                        scan_init = 1'b1;
                        state_in  = lbrm_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         lbrm_pkg::ST_SCAN: begin
            rd_en = 1'b1;
            if (cnt_ff == last_idx) begin
               state_in = lbrm_pkg::ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         lbrm_pkg::ST_DRAIN: begin
            state_in = lbrm_pkg::ST_DECIDE;
         end
         lbrm_pkg::ST_DECIDE: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            rsp_block_in = key_ff[lbrm_pkg::BlockW-1:0];
            state_in     = lbrm_pkg::ST_IDLE;
            if (flags.hit) begin
               wr_en       = 1'b1;
               wr_addr     = hit_idx;
               rsp_kind_in = lbrm_pkg::KindHit;
               rsp_slot_in = lbrm_pkg::SlotW'(hit_idx);
            end else if (!is_req_ff) begin
               rsp_kind_in = lbrm_pkg::KindMiss;
               rsp_slot_in = '0;
            end else begin
               wr_en       = 1'b1;
               uploads_in  = uploads_ff + UW'(1);
               rsp_slot_in = lbrm_pkg::SlotW'(victim);
               if (flags.free) begin
                  rsp_kind_in = lbrm_pkg::KindLoad;
               end else begin
                  rsp_kind_in  = lbrm_pkg::KindEvict;
                  rsp_block_in = old_block;
                  rsp_last_in  = 1'b0;
                  state_in     = lbrm_pkg::ST_LOAD;
               end
            end
         end
         lbrm_pkg::ST_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = lbrm_pkg::KindLoad;
            rsp_block_in = key_ff[lbrm_pkg::BlockW-1:0];
            rsp_slot_in  = lbrm_pkg::SlotW'(victim);
            rsp_last_in  = 1'b1;
            state_in     = lbrm_pkg::ST_IDLE;
         end
         default: begin
            state_in = lbrm_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_block_out = rsp_block_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_last      = rsp_last_ff;

   // An eviction is always followed in the next cycle by the closing load.
   a_evict_then_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == lbrm_pkg::KindEvict) |=>
      (rsp_valid && rsp_kind == lbrm_pkg::KindLoad && rsp_last))
      else $error("eviction not followed by load");

   a_only_evict_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_kind == lbrm_pkg::KindEvict))
      else $error("non-final result that is not an eviction");

   a_quiet_during_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbrm_pkg::ST_SCAN) |-> !rsp_valid)
      else $error("result issued during slot scan");

   a_uploads_bounded: assert property (@(posedge clock) disable iff (reset)
      uploads_ff <= MaxUpUw)
      else $error("upload count above limit");

endmodule
